// File: sv/wtnc_pkg.sv
// Shared types and constants of the width-two novelty check block.
package wtnc_pkg;

  // Novelty codes reported on the result channel
  localparam logic [1:0] NOV_ONE  = 2'd0;
  localparam logic [1:0] NOV_TWO  = 2'd1;
  localparam logic [1:0] NOV_NONE = 2'd2;

  // Input feature value field width, and stream data width in bits
  localparam int FV_W    = 4;
  localparam int TDATA_W = 8;

  // Configuration port
  localparam int         CFG_AW        = 3;
  localparam logic       REG_MAX_WIDTH = 1'b0;
  localparam logic [1:0] MAX_WIDTH_RST = 2'd2;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    logic       valid;
    logic [1:0] novelty;
    logic       overflow;
  } res_t;

endpackage

// File: sv/wtnc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wtnc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/wtnc_ctrl.sv
// Feature store, seen maps and the test-and-set sequencer of the novelty check.
module wtnc_ctrl #(
  parameter int NUM_FEATURES = 16,
  parameter int VALUE_BITS   = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [1:0]               max_width,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [wtnc_pkg::FV_W-1:0] in_value,
  input  logic                     in_changed,
  input  logic                     in_last,
  input  logic                     res_ready,
  output wtnc_pkg::res_t           res
);

  localparam int IDX_W       = $clog2(NUM_FEATURES);
  localparam int CNT_W       = $clog2(NUM_FEATURES + 1);
  localparam int SINGLE_SIZE = NUM_FEATURES << VALUE_BITS;
  localparam int SI_W        = IDX_W + VALUE_BITS;
  localparam int PAIR_SIZE   = SINGLE_SIZE * SINGLE_SIZE;
  localparam int PI_W        = $clog2(PAIR_SIZE);
  localparam int FW          = VALUE_BITS + 1;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_LOAD   = 4'd1;
  localparam logic [3:0] ST_S_RD   = 4'd2;
  localparam logic [3:0] ST_S_CHK  = 4'd3;
  localparam logic [3:0] ST_S_SET  = 4'd4;
  localparam logic [3:0] ST_P_RDC  = 4'd5;
  localparam logic [3:0] ST_P_CHKC = 4'd6;
  localparam logic [3:0] ST_P_RDF  = 4'd7;
  localparam logic [3:0] ST_P_CHKF = 4'd8;
  localparam logic [3:0] ST_P_RDM  = 4'd9;
  localparam logic [3:0] ST_P_SET  = 4'd10;
  localparam logic [3:0] ST_DONE   = 4'd11;

  logic [3:0]            state_r, state_nxt;
  logic [IDX_W-1:0]      c_r, c_nxt;
  logic [IDX_W-1:0]      f_r, f_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [1:0]            nov_r, nov_nxt;
  logic [VALUE_BITS-1:0] valc_r, valc_nxt;
  logic [SI_W-1:0]       sidx_r, sidx_nxt;
  logic [PI_W-1:0]       pidx_r, pidx_nxt;
  logic [PI_W-1:0]       clr_r, clr_nxt;

  // Feature store port signals
  logic                  fst_we;
  logic [IDX_W-1:0]      fst_raddr;
  logic [FW-1:0]         fst_wdata, fst_rdata;
  logic                  fchg;
  logic [VALUE_BITS-1:0] fval;

  // Seen map port signals
  logic                  smap_we, smap_wdata, smap_rdata;
  logic [SI_W-1:0]       smap_waddr, smap_raddr;
  logic                  pmap_we, pmap_wdata, pmap_rdata;
  logic [PI_W-1:0]       pmap_waddr;

  logic [wtnc_pkg::FV_W+VALUE_BITS-1:0] value_ext;
  logic [VALUE_BITS-1:0] value_in;
  logic                  accept, has_room, c_last, f_last, w_none, w_two;
  logic [SI_W-1:0]       idx_c, idx_f, idx_lo, idx_hi;

  // Input value trimmed or zero-extended to the stored width
  assign value_ext = {{VALUE_BITS{1'b0}}, in_value};
  assign value_in  = value_ext[VALUE_BITS-1:0];

  assign in_ready  = (state_r == ST_LOAD);
  assign accept    = in_valid && in_ready;
  assign has_room  = (count_r < CNT_W'(NUM_FEATURES));
  assign fst_we    = accept && has_room;
  assign fst_wdata = {in_changed, value_in};
  assign fchg      = fst_rdata[VALUE_BITS];
  assign fval      = fst_rdata[VALUE_BITS-1:0];

  assign c_last = ((CNT_W'(c_r) + CNT_W'(1)) == count_r);
  assign f_last = ((CNT_W'(f_r) + CNT_W'(1)) == count_r);
  assign w_none = (max_width == 2'd0);
  assign w_two  = max_width[1];

  // Pair index operands, ordered by feature index
  assign idx_c  = {c_r, valc_r};
  assign idx_f  = {f_r, fval};
  assign idx_lo = (f_r < c_r) ? idx_f : idx_c;
  assign idx_hi = (f_r < c_r) ? idx_c : idx_f;

  assign res.valid    = (state_r == ST_DONE);
  assign res.novelty  = nov_r;
  assign res.overflow = ovf_r;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    c_nxt      = c_r;
    f_nxt      = f_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    nov_nxt    = nov_r;
    valc_nxt   = valc_r;
    sidx_nxt   = sidx_r;
    pidx_nxt   = pidx_r;
    clr_nxt    = clr_r;
    fst_raddr  = c_r;
    smap_we    = 1'b0;
    smap_waddr = sidx_r;
    smap_wdata = 1'b1;
    smap_raddr = {c_r, fval};
    pmap_we    = 1'b0;
    pmap_waddr = pidx_r;
    pmap_wdata = 1'b1;

    unique case (state_r)
      ST_CLEAR: begin
        // Clearing pass over both seen maps after reset
        pmap_we    = 1'b1;
        pmap_waddr = clr_r;
        pmap_wdata = 1'b0;
        smap_we    = (clr_r < PI_W'(SINGLE_SIZE));
        smap_waddr = clr_r[SI_W-1:0];
        smap_wdata = 1'b0;
        clr_nxt    = clr_r + PI_W'(1);
        if (clr_r == PI_W'(PAIR_SIZE - 1)) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (accept) begin
          if (has_room) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            nov_nxt   = wtnc_pkg::NOV_NONE;
            c_nxt     = '0;
            state_nxt = w_none ? ST_DONE : ST_S_RD;
          end
        end
      end
      ST_S_RD: begin
        fst_raddr = c_r;
        state_nxt = ST_S_CHK;
      end
      ST_S_CHK: begin
        // Map read goes out at the single index of feature c
        sidx_nxt = {c_r, fval};
        if (fchg) begin
          state_nxt = ST_S_SET;
        end else if (c_last) begin
          c_nxt     = '0;
          state_nxt = w_two ? ST_P_RDC : ST_DONE;
        end else begin
          c_nxt     = c_r + IDX_W'(1);
          state_nxt = ST_S_RD;
        end
      end
      ST_S_SET: begin
        smap_we = 1'b1;
        if (!smap_rdata) begin
          nov_nxt = wtnc_pkg::NOV_ONE;
        end
        if (c_last) begin
          c_nxt     = '0;
          state_nxt = w_two ? ST_P_RDC : ST_DONE;
        end else begin
          c_nxt     = c_r + IDX_W'(1);
          state_nxt = ST_S_RD;
        end
      end
      ST_P_RDC: begin
        fst_raddr = c_r;
        state_nxt = ST_P_CHKC;
      end
      ST_P_CHKC: begin
        if (fchg) begin
          valc_nxt  = fval;
          f_nxt     = '0;
          state_nxt = ST_P_RDF;
        end else if (c_last) begin
          state_nxt = ST_DONE;
        end else begin
          c_nxt     = c_r + IDX_W'(1);
          state_nxt = ST_P_RDC;
        end
      end
      ST_P_RDF: begin
        fst_raddr = f_r;
        // A feature does not pair with itself
        if (f_r != c_r) begin
          state_nxt = ST_P_CHKF;
        end else if (!f_last) begin
          f_nxt = f_r + IDX_W'(1);
        end else if (c_last) begin
          state_nxt = ST_DONE;
        end else begin
          c_nxt     = c_r + IDX_W'(1);
          state_nxt = ST_P_RDC;
        end
      end
      ST_P_CHKF: begin
        pidx_nxt  = PI_W'(idx_lo) * PI_W'(SINGLE_SIZE) + PI_W'(idx_hi);
        state_nxt = ST_P_RDM;
      end
      ST_P_RDM: begin
        state_nxt = ST_P_SET;
      end
      ST_P_SET: begin
        pmap_we = 1'b1;
        if (!pmap_rdata && (nov_r == wtnc_pkg::NOV_NONE)) begin
          nov_nxt = wtnc_pkg::NOV_TWO;
        end
        if (!f_last) begin
          f_nxt     = f_r + IDX_W'(1);
          state_nxt = ST_P_RDF;
        end else if (c_last) begin
          state_nxt = ST_DONE;
        end else begin
          c_nxt     = c_r + IDX_W'(1);
          state_nxt = ST_P_RDC;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Loop indexes and operands
  always_ff @(posedge clk) begin
    c_r    <= c_nxt;
    f_r    <= f_nxt;
    nov_r  <= nov_nxt;
    valc_r <= valc_nxt;
    sidx_r <= sidx_nxt;
    pidx_r <= pidx_nxt;
  end

  wtnc_ram #(.WIDTH(FW), .DEPTH(NUM_FEATURES)) u_fstore (
    .clk   (clk),
    .we    (fst_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (fst_wdata),
    .raddr (fst_raddr),
    .rdata (fst_rdata)
  );

  wtnc_ram #(.WIDTH(1), .DEPTH(SINGLE_SIZE)) u_smap (
    .clk   (clk),
    .we    (smap_we),
    .waddr (smap_waddr),
    .wdata (smap_wdata),
    .raddr (smap_raddr),
    .rdata (smap_rdata)
  );

  wtnc_ram #(.WIDTH(1), .DEPTH(PAIR_SIZE)) u_pmap (
    .clk   (clk),
    .we    (pmap_we),
    .waddr (pmap_waddr),
    .wdata (pmap_wdata),
    .raddr (pidx_r),
    .rdata (pmap_rdata)
  );

endmodule

// File: sv/width_two_novelty_check_top.sv
// Top level of the width-two novelty check: config register, result register, sequencer.
//
// A search state is streamed in one feature per transaction on the in_ channel, in
// feature index order; tlast marks the final feature. Non-final features are stored
// as they come. On the final feature the block tests and sets the single and pair
// seen maps through one shared test-and-set sequence over the feature store and map
// RAMs, then posts one result (novelty code and overflow flag) on the out_ channel.
// The single map is walked when max_width is nonzero, and the pair map as well when
// max_width is 2 or 3; in_tready is low meanwhile. Features past NUM_FEATURES are
// dropped and the result reports overflow. After reset a clearing pass writes zero
// to every map entry, one per cycle, over (NUM_FEATURES << VALUE_BITS) squared pair
// entries (65536 by default); in_tready stays low during it, while configuration
// writes are taken. If the receiver stalls, the result waits in the output register
// and features of the next state, final one included, are still accepted; the next
// result then waits in the sequencer, with in_tready low, until the held result is
// taken. max_width is written over the APB port at byte address 0; the user must
// write it only while the block is idle, which the block itself does not enforce.
module width_two_novelty_check_top #(
  parameter int NUM_FEATURES = 16,
  parameter int VALUE_BITS   = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // in_tdata: feature_value [3:0], zero padding [7:4]; in_tuser: is_changed
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [wtnc_pkg::TDATA_W-1:0] in_tdata,
  input  logic                         in_tuser,
  input  logic                         in_tlast,
  // out_tdata: novelty [1:0], overflow [2], zero padding [7:3]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [wtnc_pkg::TDATA_W-1:0] out_tdata,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [wtnc_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  logic [1:0]     max_width_r;
  logic           out_valid_r;
  logic [1:0]     out_nov_r;
  logic           out_ovf_r;
  logic           res_ready;
  logic           reg_sel;
  wtnc_pkg::res_t res;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[2] == wtnc_pkg::REG_MAX_WIDTH);
  assign cfg_prdata = reg_sel ? {30'd0, max_width_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_width_r <= wtnc_pkg::MAX_WIDTH_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      max_width_r <= cfg_pwdata[1:0];
    end
  end

  wtnc_ctrl #(.NUM_FEATURES(NUM_FEATURES), .VALUE_BITS(VALUE_BITS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .max_width  (max_width_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_value   (in_tdata[wtnc_pkg::FV_W-1:0]),
    .in_changed (in_tuser),
    .in_last    (in_tlast),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_nov_r <= res.novelty;
      out_ovf_r <= res.overflow;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(wtnc_pkg::TDATA_W - 3){1'b0}}, out_ovf_r, out_nov_r};

endmodule

// File: sv/wtnc_checker.sv
// Port-level checker of the width-two novelty check, bound to the top level.
module wtnc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         in_tlast,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [wtnc_pkg::TDATA_W-1:0] out_tdata
);

  // A held result keeps its value until taken
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("held result changed before it was taken");

  // Novelty is never the unused code and padding stays zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] != 2'd3) && (out_tdata[wtnc_pkg::TDATA_W-1:3] == '0))
    else $error("result carries an invalid novelty code or padding");

  // The clearing pass blocks input right after reset
  assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input accepted during the map clearing pass");

  // A final feature starts evaluation, so input is held off next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input accepted while a state is being evaluated");

endmodule

bind width_two_novelty_check_top wtnc_checker u_wtnc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/width_two_novelty_check_top_tb.sv
// Self-checking testbench of the width-two novelty check block.
`timescale 1ns / 1ps

module width_two_novelty_check_top_tb;

  localparam int        RUN_ITEMS      = 800;
  localparam int        STEADY_FROM    = 700;
  localparam int        CYCLE_LIMIT    = 1000000;
  localparam int        SETTLE_CYCLES  = 40;
  localparam int        TAIL_CYCLES    = 1200;
  localparam logic [wtnc_pkg::CFG_AW-1:0] ADDR_MAX_WIDTH =
    wtnc_pkg::CFG_AW'(wtnc_pkg::REG_MAX_WIDTH) << 2;
  localparam logic [wtnc_pkg::CFG_AW-1:0] ADDR_NO_REG    = 3'd4;

  // Predicts novelty verdicts and holds the ones not yet seen on out_
  class novelty_scoreboard;
    localparam int N_FEAT = 16;

    typedef struct packed {
      logic [1:0] novelty;
      logic       overflow;
    } verdict_t;

    bit [1:0]    max_width;
    bit [3:0]    value_store[N_FEAT];
    bit          changed_flags[N_FEAT];
    int unsigned feature_count;
    bit          overflow_seen;
    bit          single_seen[256];
    bit          pair_seen[65536];
    verdict_t    pending_verdicts[$];
    int          errors;

    function new();
      max_width     = wtnc_pkg::MAX_WIDTH_RST;
      feature_count = 0;
      overflow_seen = 1'b0;
      errors        = 0;
    endfunction

    task report(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    function void set_max_width(input logic [31:0] data);
      max_width = data[1:0];
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction

    // Test-and-set over both seen maps for the loaded state
    function logic [1:0] score_state();
      logic [1:0] nov;
      logic [1:0] w;
      logic [7:0] idx_lo;
      logic [7:0] idx_hi;
      int         lo;
      int         hi;
      nov = wtnc_pkg::NOV_NONE;
      w = (max_width == 2'd3) ? 2'd2 : max_width;
      if (w == 2'd0) return wtnc_pkg::NOV_NONE;
      for (int c = 0; c < feature_count; c++) begin
        if (changed_flags[c]) begin
          idx_lo = {4'(c), value_store[c]};
          if (!single_seen[idx_lo]) nov = wtnc_pkg::NOV_ONE;
          single_seen[idx_lo] = 1'b1;
        end
      end
      if (w < 2'd2) return nov;
      for (int c = 0; c < feature_count; c++) begin
        if (!changed_flags[c]) continue;
        for (int f = 0; f < feature_count; f++) begin
          if (f == c) continue;
          lo = (f < c) ? f : c;
          hi = (f < c) ? c : f;
          idx_lo = {4'(lo), value_store[lo]};
          idx_hi = {4'(hi), value_store[hi]};
          if (!pair_seen[{idx_lo, idx_hi}] && nov == wtnc_pkg::NOV_NONE)
            nov = wtnc_pkg::NOV_TWO;
          pair_seen[{idx_lo, idx_hi}] = 1'b1;
        end
      end
      return nov;
    endfunction

    // One accepted input transaction
    function void note_feature(input logic [3:0] value, input logic changed,
                               input logic last);
      verdict_t v;
      if (feature_count < N_FEAT) begin
        value_store[feature_count]   = value;
        changed_flags[feature_count] = changed;
        feature_count++;
      end else begin
        overflow_seen = 1'b1;
      end
      if (last) begin
        v.novelty  = score_state();
        v.overflow = overflow_seen;
        pending_verdicts.push_back(v);
        feature_count = 0;
        overflow_seen = 1'b0;
      end
    endfunction

    // One accepted output transaction
    task check_result(input logic [wtnc_pkg::TDATA_W-1:0] data);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        report($sformatf("unexpected result %h", data));
      end else begin
        v = pending_verdicts.pop_front();
        if (data[1:0] !== v.novelty)
          report($sformatf("novelty %0d, expected %0d", data[1:0], v.novelty));
        if (data[2] !== v.overflow)
          report($sformatf("overflow %0b, expected %0b", data[2], v.overflow));
      end
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [wtnc_pkg::TDATA_W-1:0]  in_tdata = '0;
  logic                          in_tuser = 1'b0;
  logic                          in_tlast = 1'b0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b1;
  logic [wtnc_pkg::TDATA_W-1:0]  out_tdata;
  logic                          cfg_psel = 1'b0;
  logic                          cfg_penable = 1'b0;
  logic                          cfg_pwrite = 1'b0;
  logic [wtnc_pkg::CFG_AW-1:0]   cfg_paddr = '0;
  logic [31:0]                   cfg_pwdata = '0;
  logic [31:0]                   cfg_prdata;
  logic                          cfg_pready;

  novelty_scoreboard   sb;
  int                  items_sent = 0;
  int                  cycles = 0;
  int                  ready_hold = 0;
  bit                  steady = 1'b0;

  width_two_novelty_check_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random ready bursts, always ready in the closing stretch
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (steady) begin
      out_tready <= 1'b1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_tready <= 1'b0;
      ready_hold <= $urandom_range(0, 9);
    end else begin
      out_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 19);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  task cfg_write(input logic [wtnc_pkg::CFG_AW-1:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_MAX_WIDTH) sb.set_max_width(data);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Read max_width back; data is sampled mid-cycle of the access phase
  task cfg_read_check();
    logic [31:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_MAX_WIDTH;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(negedge clk);
      got = cfg_prdata;
      @(posedge clk);
    end while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== {30'd0, sb.max_width})
      sb.report($sformatf("max_width read %h, expected %0d", got, sb.max_width));
  endtask

  task send_feature(input logic [3:0] value, input logic changed, input logic last,
                    input int gap_pct);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, value};
    in_tuser  <= changed;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_feature(value, changed, last);
    items_sent++;
  endtask

  // Stop sending and wait for every pending verdict, then let the block go idle
  task drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random state; narrow value spans make repeats, so pairs and no-novelty show up
  task send_random_state(input int gap_pct);
    int n_feat;
    int pick;
    int span;
    int base;
    int chg_pct;
    pick = $urandom_range(0, 99);
    if (pick < 65) n_feat = $urandom_range(1, 5);
    else if (pick < 90) n_feat = $urandom_range(6, 16);
    else n_feat = $urandom_range(17, 20);
    case ($urandom_range(0, 2))
      0: span = 2;
      1: span = 4;
      default: span = 16;
    endcase
    base = $urandom_range(0, 16 - span);
    chg_pct = $urandom_range(10, 100);
    for (int i = 0; i < n_feat; i++)
      send_feature(4'(base + $urandom_range(0, span - 1)),
                   $urandom_range(0, 99) < chg_pct, i == n_feat - 1, gap_pct);
  endtask

  initial begin
    int phase_items;
    int gap_pct;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: width two from reset
    cfg_write(ADDR_MAX_WIDTH, 32'hFFFF_FFFE);
    cfg_read_check();
    send_feature(4'd15, 1'b1, 1'b1, 0);   // new single
    send_feature(4'd15, 1'b1, 1'b1, 0);   // nothing new
    send_feature(4'd5, 1'b1, 1'b0, 0);
    send_feature(4'd6, 1'b1, 1'b1, 0);    // new singles
    send_feature(4'd5, 1'b1, 1'b0, 0);
    send_feature(4'd7, 1'b0, 1'b1, 0);    // only a new pair
    send_feature(4'd5, 1'b1, 1'b0, 0);
    send_feature(4'd7, 1'b0, 1'b1, 0);    // repeat: nothing new
    // more features than the store holds
    for (int i = 0; i < 17; i++)
      send_feature(4'(i), i[0], i == 16, 0);
    drain();

    // width one: seen single, fresh pair is not looked at
    cfg_write(ADDR_MAX_WIDTH, 32'd1);
    cfg_read_check();
    send_feature(4'd5, 1'b1, 1'b0, 0);
    send_feature(4'd9, 1'b0, 1'b1, 0);
    drain();

    // width zero: never novel, maps untouched
    cfg_write(ADDR_MAX_WIDTH, 32'd0);
    cfg_read_check();
    send_feature(4'd3, 1'b1, 1'b1, 0);
    drain();

    // value three behaves as two; unmapped address is ignored
    cfg_write(ADDR_MAX_WIDTH, 32'd7);
    cfg_write(ADDR_NO_REG, 32'd0);
    cfg_read_check();
    send_feature(4'd3, 1'b1, 1'b1, 0);
    drain();

    // Random phases, each under its own max_width
    while (items_sent < RUN_ITEMS) begin
      if (items_sent >= STEADY_FROM) steady = 1'b1;
      drain();
      if ($urandom_range(0, 3) == 0) cfg_write(ADDR_NO_REG, $urandom);
      cfg_write(ADDR_MAX_WIDTH, {30'($urandom_range(0, 32'h3FFF_FFFF)), 2'(
                $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 3))});
      cfg_read_check();
      gap_pct = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
      phase_items = items_sent + $urandom_range(60, 120);
      while (items_sent < phase_items && items_sent < RUN_ITEMS) begin
        // closing stretch runs without idling on either side
        if (items_sent >= STEADY_FROM) begin
          steady  = 1'b1;
          gap_pct = 0;
        end
        send_random_state(gap_pct);
        if (!steady && $urandom_range(0, 11) == 0) drain();
      end
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
